[design/cps_pkg.sv]
// shared constants, payload types and sequencer state codes for the scheduler
`timescale 1ns / 1ps
package cps_pkg;

   localparam int MAX_TASKS = 64;
   localparam int MAX_EDGES = 1024;
   localparam int DUR_BITS  = 16;
   localparam int TIME_BITS = 23;
   localparam int NODES     = MAX_TASKS + 2;
   localparam int NODE_W    = 7;
   localparam int TASK_AW   = 6;
   localparam int EIDX_W    = 11;
   localparam int EADDR_W   = 10;
   localparam int DEG_W     = 11;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   localparam logic [1:0] CMD_SET_DUR  = 2'd0;
   localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [1:0] CMD_COMPUTE  = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic [NODE_W-1:0]   task_req;
      logic [NODE_W-1:0]   prerequisite;
      logic [DUR_BITS-1:0] duration;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]    task_index;
      logic [TIME_BITS-1:0] earliest_start;
      logic [TIME_BITS-1:0] latest_start;
      logic [TIME_BITS-1:0] project_length;
      logic                 last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLR,
      ST_CNT_RD, ST_CNT_EDGE, ST_CNT_WR,
      ST_SRC_RD, ST_SRC_CHK,
      ST_KAHN_POS, ST_KAHN_NODE, ST_KAHN_RD, ST_KAHN_EDGE, ST_KAHN_WR, ST_KAHN_SINK,
      ST_FWD_POS, ST_FWD_NODE, ST_FWD_RD, ST_FWD_EDGE, ST_FWD_ACC,
      ST_FWD_SRD, ST_FWD_SACC, ST_FWD_WR,
      ST_BWD_POS, ST_BWD_NODE, ST_BWD_DUR, ST_BWD_RD, ST_BWD_EDGE, ST_BWD_ACC,
      ST_BWD_WR,
      ST_EMIT_RD, ST_EMIT_OUT
   } cps_state_type;

   typedef struct packed {
      cps_state_type step;
      logic          load;
      logic          compute;
   } cps_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_end;
      logic edge_ok;
      logic hit_pre;
      logic hit_dep;
      logic t_over;
      logic pos_end;
      logic pos_zero;
      logic node_is_sink;
   } cps_status_type;

endpackage

[design/cps_ctrl.sv]
// sequencer for load, graph ordering, forward and backward passes and row output
`timescale 1ns / 1ps
module cps_ctrl import cps_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     command,
   input  cps_status_type status,
   output cps_cmd_type    cmd,
   output logic           busy
);

   cps_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.step    = state_ff;
      cmd.load    = 1'b0;
      cmd.compute = 1'b0;
      busy        = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (command == CMD_COMPUTE) begin
                  cmd.compute = 1'b1;
                  state_in    = ST_CLR;
               end
            end
         end
         ST_CLR:       if (status.clr_last) state_in = ST_CNT_RD;
         ST_CNT_RD:    state_in = status.scan_end ? ST_SRC_RD : ST_CNT_EDGE;
         ST_CNT_EDGE:  state_in = status.edge_ok ? ST_CNT_WR : ST_CNT_RD;
         ST_CNT_WR:    state_in = ST_CNT_RD;
         ST_SRC_RD:    state_in = status.t_over ? ST_KAHN_POS : ST_SRC_CHK;
         ST_SRC_CHK:   state_in = ST_SRC_RD;
         ST_KAHN_POS:  state_in = status.pos_end ? ST_FWD_POS : ST_KAHN_NODE;
         ST_KAHN_NODE: state_in = status.node_is_sink ? ST_KAHN_POS : ST_KAHN_RD;
         ST_KAHN_RD:   state_in = status.scan_end ? ST_KAHN_SINK : ST_KAHN_EDGE;
         ST_KAHN_EDGE: state_in = status.hit_pre ? ST_KAHN_WR : ST_KAHN_RD;
         ST_KAHN_WR:   state_in = ST_KAHN_RD;
         ST_KAHN_SINK: state_in = ST_KAHN_POS;
         ST_FWD_POS:   state_in = status.pos_end ? ST_BWD_POS : ST_FWD_NODE;
         ST_FWD_NODE:  state_in = status.node_is_sink ? ST_FWD_SRD : ST_FWD_RD;
         ST_FWD_RD:    state_in = status.scan_end ? ST_FWD_WR : ST_FWD_EDGE;
         ST_FWD_EDGE:  state_in = status.hit_dep ? ST_FWD_ACC : ST_FWD_RD;
         ST_FWD_ACC:   state_in = ST_FWD_RD;
         ST_FWD_SRD:   state_in = status.t_over ? ST_FWD_WR : ST_FWD_SACC;
         ST_FWD_SACC:  state_in = ST_FWD_SRD;
         ST_FWD_WR:    state_in = ST_FWD_POS;
         ST_BWD_POS:   state_in = status.pos_zero ? ST_EMIT_RD : ST_BWD_NODE;
         ST_BWD_NODE:  state_in = status.node_is_sink ? ST_BWD_POS : ST_BWD_DUR;
         ST_BWD_DUR:   state_in = ST_BWD_RD;
         ST_BWD_RD:    state_in = status.scan_end ? ST_BWD_WR : ST_BWD_EDGE;
         ST_BWD_EDGE:  state_in = status.hit_pre ? ST_BWD_ACC : ST_BWD_RD;
         ST_BWD_ACC:   state_in = ST_BWD_RD;
         ST_BWD_WR:    state_in = ST_BWD_POS;
         ST_EMIT_RD:   state_in = status.t_over ? ST_IDLE : ST_EMIT_OUT;
         ST_EMIT_OUT:  state_in = ST_EMIT_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

endmodule

[design/cps_dp.sv]
// datapath: task and edge stores, degree, order and time memories, counters
`timescale 1ns / 1ps
module cps_dp import cps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cps_cmd_type         cmd,
   input  req_type             req_data,
   input  logic                csr_we,
   input  logic [NODE_W-1:0]   csr_wdata,
   output cps_status_type      status,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   // memories
   logic [2*NODE_W-1:0]  edge_mem  [MAX_EDGES];
   logic [DUR_BITS-1:0]  dur_mem   [MAX_TASKS];
   logic [DEG_W-1:0]     deg_mem   [NODES];
   logic [NODE_W-1:0]    topo_mem  [NODES];
   logic [TIME_BITS-1:0] earl_mem  [NODES];
   logic [TIME_BITS-1:0] late_mem  [NODES];

   logic [2*NODE_W-1:0]  edge_q;
   logic [DUR_BITS-1:0]  dur_q;
   logic [DEG_W-1:0]     deg_q;
   logic [NODE_W-1:0]    topo_q;
   logic [TIME_BITS-1:0] earl_q, late_q;

   logic [NODE_W-1:0]    task_count_ff;
   logic [EIDX_W-1:0]    edge_count_ff;
   logic [EIDX_W-1:0]    idx_ff;
   logic [NODE_W-1:0]    t_ff, pos_ff, len_ff, k_ff, dd_ff, sink_deg_ff;
   logic [TIME_BITS-1:0] acc_ff, proj_ff;
   logic [DUR_BITS-1:0]  dk_ff;
   logic [MAX_TASKS-1:0] has_succ_ff;

   logic [NODE_W-1:0]    n, sink, e_pre, e_dep;
   logic                 pre_ok, dep_ok, tr_ok, pr_ok;
   logic [TIME_BITS:0]   fsum;
   logic [TIME_BITS-1:0] fwd_c, bwd_c, sink_c, bwd_l;
   logic [NODE_W-1:0]    t_m1, k_m1;

   // address and write controls
   logic [NODE_W-1:0]    deg_ra, deg_wa, topo_ra, earl_ra, earl_wa, late_ra, late_wa;
   logic [DEG_W-1:0]     deg_wd;
   logic [NODE_W-1:0]    topo_wd;
   logic [TIME_BITS-1:0] earl_wd, late_wd;
   logic                 deg_we, topo_we, earl_we, late_we;
   logic [NODE_W-1:0]    dur_node;

   assign n      = (task_count_ff > NODE_W'(MAX_TASKS)) ? NODE_W'(MAX_TASKS) : task_count_ff;
   assign sink   = n + NODE_W'(1);
   assign e_pre  = edge_q[NODE_W-1:0];
   assign e_dep  = edge_q[2*NODE_W-1:NODE_W];
   assign pre_ok = (e_pre != '0) && (e_pre <= n);
   assign dep_ok = (e_dep != '0) && (e_dep <= n);
   assign tr_ok  = (req_data.task_req != '0) && (req_data.task_req <= n);
   assign pr_ok  = (req_data.prerequisite != '0) && (req_data.prerequisite <= n);
   assign t_m1   = t_ff - NODE_W'(1);
   assign k_m1   = k_ff - NODE_W'(1);

   // saturating time arithmetic
   assign fsum   = {1'b0, earl_q} + (TIME_BITS+1)'(dur_q);
   assign fwd_c  = fsum[TIME_BITS] ? TIME_MAX : fsum[TIME_BITS-1:0];
   assign bwd_c  = (late_q < TIME_BITS'(dk_ff)) ? '0 : late_q - TIME_BITS'(dk_ff);
   assign sink_c = (proj_ff < TIME_BITS'(dk_ff)) ? '0 : proj_ff - TIME_BITS'(dk_ff);
   assign bwd_l  = (!has_succ_ff[k_m1[TASK_AW-1:0]] && sink_c < acc_ff) ? sink_c : acc_ff;

   assign status.clr_last     = (t_ff == NODE_W'(NODES - 1));
   assign status.scan_end     = (idx_ff >= edge_count_ff);
   assign status.edge_ok      = pre_ok && dep_ok;
   assign status.hit_pre      = pre_ok && dep_ok && (e_pre == k_ff);
   assign status.hit_dep      = pre_ok && dep_ok && (e_dep == k_ff);
   assign status.t_over       = (t_ff > n);
   assign status.pos_end      = (pos_ff == len_ff);
   assign status.pos_zero     = (pos_ff == '0);
   assign status.node_is_sink = (topo_q == sink);

   always_comb begin
      deg_ra  = t_ff;
      deg_wa  = dd_ff;
      deg_wd  = deg_q + DEG_W'(1);
      deg_we  = 1'b0;
      topo_ra = pos_ff;
      topo_wd = t_ff;
      topo_we = 1'b0;
      earl_ra = t_ff;
      earl_wa = k_ff;
      earl_wd = acc_ff;
      earl_we = 1'b0;
      late_ra = t_ff;
      late_wa = k_ff;
      late_wd = bwd_l;
      late_we = 1'b0;
      dur_node = t_ff;
      unique case (cmd.step)
         ST_CLR: begin
            deg_wa  = t_ff;
            deg_wd  = '0;
            deg_we  = 1'b1;
            earl_wa = t_ff;
            earl_wd = '0;
            earl_we = 1'b1;
            late_wa = t_ff;
            late_wd = TIME_MAX;
            late_we = 1'b1;
         end
         ST_CNT_EDGE, ST_KAHN_EDGE: deg_ra = e_dep;
         ST_CNT_WR: deg_we = 1'b1;
         ST_SRC_CHK: topo_we = (deg_q == '0);
         ST_KAHN_WR: begin
            deg_wd  = deg_q - DEG_W'(1);
            deg_we  = (deg_q != '0);
            topo_wd = dd_ff;
            topo_we = (deg_q == DEG_W'(1));
         end
         ST_KAHN_SINK: begin
            topo_wd = sink;
            topo_we = !has_succ_ff[k_m1[TASK_AW-1:0]] && (sink_deg_ff == NODE_W'(1));
         end
         ST_FWD_EDGE: begin
            earl_ra  = e_pre;
            dur_node = e_pre;
         end
         ST_FWD_WR: earl_we = 1'b1;
         ST_BWD_POS: topo_ra = pos_ff - NODE_W'(1);
         ST_BWD_NODE: dur_node = topo_q;
         ST_BWD_EDGE: late_ra = e_dep;
         ST_BWD_WR: late_we = 1'b1;
         default: ;
      endcase
   end

   // memory ports, reads registered
   always_ff @(posedge clock) begin
      edge_q <= edge_mem[idx_ff[EADDR_W-1:0]];
      dur_q  <= dur_mem[TASK_AW'(dur_node - NODE_W'(1))];
      deg_q  <= deg_mem[deg_ra];
      topo_q <= topo_mem[topo_ra];
      earl_q <= earl_mem[earl_ra];
      late_q <= late_mem[late_ra];
      if (deg_we) deg_mem[deg_wa] <= deg_wd;
      if (topo_we) topo_mem[len_ff] <= topo_wd;
      if (earl_we) earl_mem[earl_wa] <= earl_wd;
      if (late_we) late_mem[late_wa] <= late_wd;
      if (cmd.load && req_data.command == CMD_SET_DUR && tr_ok) begin
         dur_mem[TASK_AW'(req_data.task_req - NODE_W'(1))] <= req_data.duration;
      end
      if (cmd.load && req_data.command == CMD_ADD_EDGE && tr_ok && pr_ok
          && edge_count_ff < EIDX_W'(MAX_EDGES)) begin
         edge_mem[edge_count_ff[EADDR_W-1:0]] <= {req_data.task_req, req_data.prerequisite};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= NODE_W'(1);
         edge_count_ff <= '0;
      end else begin
         if (csr_we) task_count_ff <= csr_wdata;
         if (cmd.load && req_data.command == CMD_ADD_EDGE && tr_ok && pr_ok
             && edge_count_ff < EIDX_W'(MAX_EDGES)) begin
            edge_count_ff <= edge_count_ff + EIDX_W'(1);
         end
         if (cmd.step == ST_EMIT_RD && status.t_over) edge_count_ff <= '0;
      end
   end

   // counters and accumulators
   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         t_ff        <= '0;
         idx_ff      <= '0;
         len_ff      <= '0;
         sink_deg_ff <= '0;
         proj_ff     <= '0;
         has_succ_ff <= '0;
      end
      unique case (cmd.step)
         ST_CLR: t_ff <= t_ff + NODE_W'(1);
         ST_CNT_RD: if (status.scan_end) t_ff <= NODE_W'(1);
         ST_CNT_EDGE: begin
            if (status.edge_ok) begin
               has_succ_ff[TASK_AW'(e_pre - NODE_W'(1))] <= 1'b1;
               dd_ff <= e_dep;
            end else begin
               idx_ff <= idx_ff + EIDX_W'(1);
            end
         end
         ST_CNT_WR: idx_ff <= idx_ff + EIDX_W'(1);
         ST_SRC_RD: if (status.t_over) pos_ff <= '0;
         ST_SRC_CHK: begin
            if (deg_q == '0) len_ff <= len_ff + NODE_W'(1);
            if (!has_succ_ff[t_m1[TASK_AW-1:0]]) sink_deg_ff <= sink_deg_ff + NODE_W'(1);
            t_ff <= t_ff + NODE_W'(1);
         end
         ST_KAHN_POS: if (status.pos_end) pos_ff <= '0;
         ST_KAHN_NODE: begin
            k_ff   <= topo_q;
            idx_ff <= '0;
            if (status.node_is_sink) pos_ff <= pos_ff + NODE_W'(1);
         end
         ST_KAHN_EDGE: begin
            if (status.hit_pre) dd_ff <= e_dep;
            else idx_ff <= idx_ff + EIDX_W'(1);
         end
         ST_KAHN_WR: begin
            if (deg_q == DEG_W'(1)) len_ff <= len_ff + NODE_W'(1);
            idx_ff <= idx_ff + EIDX_W'(1);
         end
         ST_KAHN_SINK: begin
            if (!has_succ_ff[k_m1[TASK_AW-1:0]] && sink_deg_ff != '0) begin
               sink_deg_ff <= sink_deg_ff - NODE_W'(1);
               if (sink_deg_ff == NODE_W'(1)) len_ff <= len_ff + NODE_W'(1);
            end
            pos_ff <= pos_ff + NODE_W'(1);
         end
         ST_FWD_NODE: begin
            k_ff   <= topo_q;
            acc_ff <= '0;
            idx_ff <= '0;
            t_ff   <= NODE_W'(1);
         end
         ST_FWD_EDGE: if (!status.hit_dep) idx_ff <= idx_ff + EIDX_W'(1);
         ST_FWD_ACC: begin
            if (fwd_c > acc_ff) acc_ff <= fwd_c;
            idx_ff <= idx_ff + EIDX_W'(1);
         end
         ST_FWD_SACC: begin
            if (!has_succ_ff[t_m1[TASK_AW-1:0]] && fwd_c > acc_ff) acc_ff <= fwd_c;
            t_ff <= t_ff + NODE_W'(1);
         end
         ST_FWD_WR: begin
            if (k_ff == sink) proj_ff <= acc_ff;
            pos_ff <= pos_ff + NODE_W'(1);
         end
         ST_BWD_POS: if (status.pos_zero) t_ff <= NODE_W'(1);
         ST_BWD_NODE: begin
            k_ff   <= topo_q;
            idx_ff <= '0;
            acc_ff <= TIME_MAX;
            if (status.node_is_sink) pos_ff <= pos_ff - NODE_W'(1);
         end
         ST_BWD_DUR: dk_ff <= dur_q;
         ST_BWD_EDGE: if (!status.hit_pre) idx_ff <= idx_ff + EIDX_W'(1);
         ST_BWD_ACC: begin
            if (bwd_c < acc_ff) acc_ff <= bwd_c;
            idx_ff <= idx_ff + EIDX_W'(1);
         end
         ST_BWD_WR: pos_ff <= pos_ff - NODE_W'(1);
         ST_EMIT_OUT: t_ff <= t_ff + NODE_W'(1);
         default: ;
      endcase
   end

   assign rsp_valid               = (cmd.step == ST_EMIT_OUT);
   assign rsp_data.task_index     = t_ff;
   assign rsp_data.earliest_start = earl_q;
   assign rsp_data.latest_start   = late_q;
   assign rsp_data.project_length = proj_ff;
   assign rsp_data.last           = (t_ff == n);

endmodule

[design/critical_path_scheduler_unit.sv]
// top level of the critical path scheduler: sequencer plus datapath
//
//  channel | ports                     | handshake
//  --------+---------------------------+---------------------------------
//  request | start, busy, req_data     | taken when start and not busy
//  result  | rsp_valid, rsp_data       | one-cycle strobe, no back-pressure
//  config  | csr_we, csr_wdata         | written when csr_we is high
//
// set-duration and add-edge items leave the block idle, so they can be taken back to back.
// a compute item holds busy while it clears the node memories, counts in-degrees,
// finds sources, orders the tasks, walks the edges in a forward and a backward
// pass and emits the result rows; the sink is handled by its own scans.
// a read state comes before each result row; reset is synchronous and leaves the
// block idle with task_count 1 and no stored edges.
`timescale 1ns / 1ps
module critical_path_scheduler_unit import cps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [NODE_W-1:0] csr_wdata
);

   cps_cmd_type    cmd;
   cps_status_type status;

   cps_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   cps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[design/cps_checker.sv]
// port-level checks for the scheduler, bound to the top level
`timescale 1ns / 1ps
module cps_checker import cps_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // rows only appear during a compute
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result row while idle");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command == CMD_COMPUTE |=> busy)
      else $error("compute item did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command != CMD_COMPUTE |=> !busy)
      else $error("load item raised busy");

   // a closing read state follows the last row before busy drops
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> ##1 !busy)
      else $error("still busy after last row");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("rows on consecutive cycles");

endmodule

bind critical_path_scheduler_unit cps_checker u_cps_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[tb/tb.sv]
// self-checking testbench for the critical path scheduler unit
`timescale 1ns / 1ps
module tb;
   import cps_pkg::*;

   localparam int unsigned TMAX = 8388607;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      bit              is_cfg;
      logic [6:0]      cfg_value;
      req_type         req;
   } stim_entry;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [6:0] csr_wdata;

   critical_path_scheduler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // scheduler state as the testbench sees it
   logic [6:0]  sched_count;
   logic [15:0] task_dur [1:64];
   logic [6:0]  link_pre [0:1023];
   logic [6:0]  link_dep [0:1023];
   int          link_count;

   stim_entry   stim_q[$];
   rsp_type     row_q[$];
   int          errors, rows_seen, items_taken, computes_taken;
   int          gap, quiet, cycles;
   bit          calm;

   // generation-side tracking so no compute reads an unset duration
   int          gen_n;
   bit          dur_known [1:64];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned sat_add(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > TMAX) ? TMAX : int'(s);
   endfunction

   function automatic int unsigned sat_sub(int unsigned a, int unsigned b);
      return (a < b) ? 0 : a - b;
   endfunction

   function automatic bool_ok(int p, int d, int n);
      return p >= 1 && p <= n && d >= 1 && d <= n;
   endfunction

   // critical path schedule: ordering, forward and backward passes, rows queued
   task automatic schedule_rows();
      int n, sink, olen, pos, i, t, k;
      int unsigned indeg [0:65];
      int unsigned outdeg [0:65];
      bit          src [0:65];
      bit          snk [0:65];
      int          order [0:65];
      int unsigned est [0:65];
      int unsigned lst [0:65];
      int unsigned e, l, c;
      rsp_type     row;
      n = (sched_count > 64) ? 64 : sched_count;
      sink = n + 1;
      for (i = 0; i < 66; i++) begin
         indeg[i] = 0; outdeg[i] = 0; src[i] = 0; snk[i] = 0;
         est[i] = 0; lst[i] = TMAX; order[i] = 0;
      end
      for (i = 0; i < link_count; i++)
         if (bool_ok(link_pre[i], link_dep[i], n)) begin
            indeg[link_dep[i]]++;
            outdeg[link_pre[i]]++;
         end
      for (t = 1; t <= n; t++) begin
         src[t] = indeg[t] == 0;
         if (src[t]) indeg[t] = 1;
         snk[t] = outdeg[t] == 0;
         if (snk[t]) indeg[sink]++;
      end
      order[0] = 0;
      olen = 1;
      for (pos = 0; pos < olen; pos++) begin
         k = order[pos];
         for (i = 0; i < ((k == 0) ? n : (k <= n ? link_count + 1 : 0)); i++) begin
            int v;
            v = -1;
            if (k == 0) begin
               if (src[i + 1]) v = i + 1;
            end else if (i == link_count) begin
               if (snk[k]) v = sink;
            end else if (bool_ok(link_pre[i], link_dep[i], n) && link_pre[i] == k) begin
               v = link_dep[i];
            end
            if (v >= 0 && v < 66 && indeg[v] != 0) begin
               indeg[v]--;
               if (indeg[v] == 0 && olen < 66) begin
                  order[olen] = v;
                  olen++;
               end
            end
         end
      end
      for (pos = 1; pos < olen; pos++) begin
         k = order[pos];
         e = est[k];
         if (k >= 1 && k <= n) begin
            for (i = 0; i < link_count; i++)
               if (bool_ok(link_pre[i], link_dep[i], n) && link_dep[i] == k) begin
                  c = sat_add(est[link_pre[i]], task_dur[link_pre[i]]);
                  if (c > e) e = c;
               end
         end else if (k == sink) begin
            for (t = 1; t <= n; t++)
               if (snk[t]) begin
                  c = sat_add(est[t], task_dur[t]);
                  if (c > e) e = c;
               end
         end
         est[k] = e;
      end
      lst[0] = 0;
      lst[sink] = est[sink];
      for (pos = olen - 1; pos >= 1; pos--) begin
         k = order[pos];
         if (k >= 1 && k <= n) begin
            l = lst[k];
            for (i = 0; i < link_count; i++)
               if (bool_ok(link_pre[i], link_dep[i], n) && link_pre[i] == k) begin
                  c = sat_sub(lst[link_dep[i]], task_dur[k]);
                  if (c < l) l = c;
               end
            if (snk[k]) begin
               c = sat_sub(lst[sink], task_dur[k]);
               if (c < l) l = c;
            end
            lst[k] = l;
         end
      end
      for (t = 1; t <= n; t++) begin
         row.task_index     = t[6:0];
         row.earliest_start = est[t][22:0];
         row.latest_start   = lst[t][22:0];
         row.project_length = est[sink][22:0];
         row.last           = (t == n);
         row_q.insert(row_q.size(), row);
      end
      link_count = 0;
   endtask

   task automatic apply_item(req_type r);
      int n;
      n = (sched_count > 64) ? 64 : sched_count;
      case (r.command)
         CMD_SET_DUR: begin
            if (r.task_req >= 1 && r.task_req <= n) task_dur[r.task_req] = r.duration;
         end
         CMD_ADD_EDGE: begin
            if (bool_ok(r.prerequisite, r.task_req, n) && link_count < MAX_EDGES) begin
               link_pre[link_count] = r.prerequisite;
               link_dep[link_count] = r.task_req;
               link_count++;
            end
         end
         CMD_COMPUTE: begin
            computes_taken++;
            schedule_rows();
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // stimulus helpers
   task automatic push_raw(logic [1:0] cmd, int tr, int pr, int du);
      stim_entry s;
      s.is_cfg = 0;
      s.cfg_value = '0;
      s.req.command = cmd;
      s.req.task_req = tr[6:0];
      s.req.prerequisite = pr[6:0];
      s.req.duration = du[15:0];
      stim_q.insert(stim_q.size(), s);
   endtask

   task automatic push_cfg(int v);
      stim_entry s;
      s.is_cfg = 1;
      s.cfg_value = v[6:0];
      s.req = '0;
      stim_q.insert(stim_q.size(), s);
      gen_n = (v > 64) ? 64 : v;
   endtask

   task automatic push_dur(int tr, int du);
      push_raw(CMD_SET_DUR, tr, $urandom_range(0, 127), du);
      if (tr >= 1 && tr <= gen_n) dur_known[tr] = 1;
   endtask

   task automatic push_compute();
      for (int t = 1; t <= gen_n; t++)
         if (!dur_known[t]) push_dur(t, $urandom_range(0, 65535));
      push_raw(CMD_COMPUTE, $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 65535));
   endtask

   // driver
   always @(posedge clock) begin : driver
      logic    nstart, nwe;
      req_type nreq;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         quiet = 0;
      end else begin
         nstart = start;
         nwe = 1'b0;
         nreq = req_data;
         if (start && !busy) begin
            apply_item(req_data);
            items_taken++;
            nstart = 1'b0;
         end
         if (!busy && !start && row_q.size() == 0) quiet++;
         else quiet = 0;
         if (!nstart) begin
            if (gap > 0) begin
               gap--;
            end else if (stim_q.size() > 0) begin
               if (stim_q[0].is_cfg) begin
                  // wait out any compute that emits no rows
                  if (quiet >= 40) begin
                     nwe = 1'b1;
                     csr_wdata <= stim_q[0].cfg_value;
                     sched_count = stim_q[0].cfg_value;
                     void'(stim_q.pop_front());
                  end
               end else begin
                  nstart = 1'b1;
                  nreq = stim_q[0].req;
                  void'(stim_q.pop_front());
                  if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
               end
            end
         end
         start <= nstart;
         csr_we <= nwe;
         req_data <= nreq;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         rows_seen++;
         if (row_q.size() == 0) begin
            errors++;
            $display("unexpected row at %0t: task %0d", $realtime, rsp_data.task_index);
         end else begin
            want = row_q.pop_front();
            if (rsp_data.task_index !== want.task_index)
               report_mismatch("task_index", 32'(rsp_data.task_index),
                               32'(want.task_index));
            if (rsp_data.earliest_start !== want.earliest_start)
               report_mismatch("earliest_start", 32'(rsp_data.earliest_start),
                               32'(want.earliest_start));
            if (rsp_data.latest_start !== want.latest_start)
               report_mismatch("latest_start", 32'(rsp_data.latest_start),
                               32'(want.latest_start));
            if (rsp_data.project_length !== want.project_length)
               report_mismatch("project_length", 32'(rsp_data.project_length),
                               32'(want.project_length));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** critical_path_scheduler_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int n, ne, p, d;
      start = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_data = '0;
      reset = 1'b1;
      sched_count = 7'd1;
      link_count = 0;
      errors = 0; rows_seen = 0; items_taken = 0; computes_taken = 0;
      gap = 0; quiet = 0; cycles = 0; calm = 0;
      gen_n = 1;
      for (int t = 1; t <= 64; t++) begin
         dur_known[t] = 0;
         task_dur[t] = '0;
      end

      // directed: small chain with extreme durations and out-of-range names
      push_cfg(4);
      push_dur(1, 0);
      push_dur(2, 65535);
      push_dur(3, 21845);
      push_dur(4, 43690);
      push_dur(0, 777);
      push_dur(100, 555);
      push_raw(CMD_ADD_EDGE, 2, 1, 0);
      push_raw(CMD_ADD_EDGE, 3, 2, 0);
      push_raw(CMD_ADD_EDGE, 3, 1, 0);
      push_raw(CMD_ADD_EDGE, 2, 0, 0);
      push_raw(CMD_ADD_EDGE, 127, 1, 65535);
      push_raw(CMD_UNUSED, 127, 127, 65535);
      push_compute();
      // self edge and a two-task cycle, plus a duplicate edge
      push_raw(CMD_ADD_EDGE, 1, 1, 0);
      push_raw(CMD_ADD_EDGE, 3, 4, 0);
      push_raw(CMD_ADD_EDGE, 4, 3, 0);
      push_raw(CMD_ADD_EDGE, 4, 2, 0);
      push_raw(CMD_ADD_EDGE, 4, 2, 0);
      push_compute();
      // stale edge above a shrunk task count
      push_cfg(10);
      push_raw(CMD_ADD_EDGE, 9, 8, 0);
      push_raw(CMD_ADD_EDGE, 2, 1, 0);
      push_cfg(3);
      push_compute();
      // zero tasks: no rows, edges cleared
      push_raw(CMD_ADD_EDGE, 2, 1, 0);
      push_cfg(0);
      push_compute();
      // count above the maximum acts as 64, a chain with big durations
      push_cfg(127);
      for (int t = 1; t <= 64; t++) push_dur(t, 65535 - $urandom_range(0, 3));
      for (int t = 2; t <= 16; t++) push_raw(CMD_ADD_EDGE, t, t - 1, 0);
      push_compute();

      // random phases: mostly acyclic graphs, some noise and back edges
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 5))
            0: n = 1;
            1: n = 2;
            default: n = $urandom_range(3, 10);
         endcase
         push_cfg(n);
         for (int t = 1; t <= n; t++)
            if ($urandom_range(0, 2) != 0) push_dur(t, $urandom_range(0, 65535));
         ne = $urandom_range(0, 10);
         for (int i = 0; i < ne; i++) begin
            p = $urandom_range(1, n);
            d = $urandom_range(1, n);
            case ($urandom_range(0, 9))
               0: push_raw(CMD_ADD_EDGE, $urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 65535));
               1: push_raw(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 65535));
               2: push_dur($urandom_range(1, n), $urandom_range(0, 65535));
               3: push_raw(CMD_ADD_EDGE, d, p, 0);
               default: begin
                  if (p == d) push_raw(CMD_ADD_EDGE, p, p, 0);
                  else if (p < d) push_raw(CMD_ADD_EDGE, d, p, $urandom_range(0, 65535));
                  else push_raw(CMD_ADD_EDGE, p, d, $urandom_range(0, 65535));
               end
            endcase
         end
         push_compute();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (stim_q.size() < 40);
      calm = 1;
      wait (stim_q.size() == 0 && !start);
      wait (row_q.size() == 0 && !busy);
      repeat (200) @(posedge clock);
      $display("items accepted: %0d, computes: %0d, rows checked: %0d",
               items_taken, computes_taken, rows_seen);
      $display("covered cyclic graphs, stale edges, zero and oversized counts, random graphs");
      if (errors == 0 && row_q.size() == 0)
         $display("** critical_path_scheduler_unit: PASSED **");
      else
         $display("** critical_path_scheduler_unit: FAILED **");
      $finish;
   end

endmodule
